[rtl/tx_command_word_parser_core_macros.svh]
// Assertion macros shared by the transmit command word parser modules.
`ifndef TX_COMMAND_WORD_PARSER_CORE_MACROS_SVH
`define TX_COMMAND_WORD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCWP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCWP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcwp_pkg.sv]
// Types, constants and helper functions of the transmit command word parser.
`timescale 1ns / 1ps
package tcwp_pkg;

    localparam int WORD_W     = 32;
    localparam int TAG_W      = 16;
    localparam int SIZE_W     = 11;
    localparam int SKIP_W     = 5;
    localparam int PAD_W      = 3;
    localparam int HELD_W     = 12;
    localparam int SCOUNT_W   = 8;
    localparam int DEPTH_CMP_W = 11;
    localparam int COUNT_W    = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HELD_W-1:0] CAPACITY_RESET = 12'd1152;

    // End alignment codes of command A bits 25:24.
    localparam logic [1:0] ALIGN_4 = 2'd1;
    localparam logic [1:0] ALIGN_8 = 2'd2;

    // Register index decoded from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMDB = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic              dump;
        logic [WORD_W-1:0] word;
        logic              status_room;
        logic              status_fill;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  out_bytes;
        logic [COUNT_W-1:0] out_count;
        logic               packet_end;
        logic               status_push;
        logic [TAG_W-1:0]   status_word;
        logic               status_full_flag;
        logic               ioc_flag;
        logic               overflow_flag;
    } result_t;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
        logic [WORD_W-1:0] m;
        case (n)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

[rtl/tcwp_front.sv]
// Front stage: registers each incoming transfer and classifies it.
`timescale 1ns / 1ps
module tcwp_front #(
    parameter int STATUS_FIFO_DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [tcwp_pkg::WORD_W-1:0]    word,
    input  logic [tcwp_pkg::SCOUNT_W-1:0]  status_fifo_count,
    output logic                           push_valid,
    input  logic                           push_ready,
    output tcwp_pkg::item_t                push_item
);

    logic                                 valid_reg;
    logic                                 valid_next;
    tcwp_pkg::item_t                      item_reg;
    tcwp_pkg::item_t                      item_next;
    logic [tcwp_pkg::DEPTH_CMP_W-1:0]     scount_ext;
    logic [tcwp_pkg::DEPTH_CMP_W-1:0]     depth_val;

    assign scount_ext = {{(tcwp_pkg::DEPTH_CMP_W - tcwp_pkg::SCOUNT_W){1'b0}},
                         status_fifo_count};
    assign depth_val  = tcwp_pkg::DEPTH_CMP_W'(STATUS_FIFO_DEPTH);

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready)
        begin
            valid_next            = in_valid;
            item_next.dump        = cmd;
            item_next.word        = word;
            // Status FIFO room is judged here so the back needs no wide compare.
            item_next.status_room = scount_ext < depth_val;
            item_next.status_fill = (scount_ext + 11'd1) >= depth_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

[rtl/tcwp_queue.sv]
// Short register queue between the front and back stages.
`timescale 1ns / 1ps
`include "tx_command_word_parser_core_macros.svh"
module tcwp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tcwp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tcwp_pkg::item_t pop_item
);

    tcwp_pkg::item_t                   entry_reg [tcwp_pkg::QUEUE_DEPTH];
    logic [tcwp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [tcwp_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [tcwp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [tcwp_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [tcwp_pkg::QCNT_W-1:0]       count_reg;
    logic [tcwp_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = count_reg != tcwp_pkg::QCNT_W'(tcwp_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcwp_pkg::QPTR_W'(tcwp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + tcwp_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcwp_pkg::QPTR_W'(tcwp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + tcwp_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tcwp_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - tcwp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `TCWP_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
        count_reg <= tcwp_pkg::QCNT_W'(tcwp_pkg::QUEUE_DEPTH),
        "queue occupancy beyond its depth")

endmodule

[rtl/tcwp_back.sv]
// Back stage: parser state, byte extraction and the registered result.
`timescale 1ns / 1ps
`include "tx_command_word_parser_core_macros.svh"
module tcwp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcwp_pkg::HELD_W-1:0]   capacity,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  tcwp_pkg::item_t               item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcwp_pkg::result_t             result
);

    tcwp_pkg::phase_t                  phase_reg;
    tcwp_pkg::phase_t                  phase_next;
    logic                              ioc_reg;
    logic                              ioc_next;
    logic                              last_reg;
    logic                              last_next;
    logic [1:0]                        align_reg;
    logic [1:0]                        align_next;
    logic [tcwp_pkg::TAG_W-1:0]        tag_reg;
    logic [tcwp_pkg::TAG_W-1:0]        tag_next;
    logic [tcwp_pkg::SIZE_W-1:0]       bytes_left_reg;
    logic [tcwp_pkg::SIZE_W-1:0]       bytes_left_next;
    logic [tcwp_pkg::SKIP_W-1:0]       skip_reg;
    logic [tcwp_pkg::SKIP_W-1:0]       skip_next;
    logic [tcwp_pkg::PAD_W-1:0]        pad_reg;
    logic [tcwp_pkg::PAD_W-1:0]        pad_next;
    logic [tcwp_pkg::HELD_W-1:0]       held_reg;
    logic [tcwp_pkg::HELD_W-1:0]       held_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    tcwp_pkg::result_t                 result_reg;
    tcwp_pkg::result_t                 result_next;
    tcwp_pkg::result_t                 res;
    logic                              take;
    logic [11:0]                       span;
    logic [11:0]                       total;
    logic [tcwp_pkg::COUNT_W-1:0]      take_n;
    logic [tcwp_pkg::COUNT_W-1:0]      emit_n;
    logic [tcwp_pkg::WORD_W-1:0]       shifted;

    assign item_ready = !out_valid_reg || out_ready;
    assign take       = item_valid && item_ready;
    assign out_valid  = out_valid_reg;
    assign result     = result_reg;

    // Words in the buffer (command B) and bytes still to take (data word).
    assign span    = {1'b0, bytes_left_reg} + {7'b0, skip_reg} + 12'd3;
    assign total   = {1'b0, bytes_left_reg} + {7'b0, skip_reg};
    assign take_n  = (total < 12'd4) ? total[2:0] : 3'd4;
    assign emit_n  = take_n - {1'b0, skip_reg[1:0]};
    assign shifted = item.word >> {skip_reg[1:0], 3'b000};

    always_comb
    begin
        phase_next      = phase_reg;
        ioc_next        = ioc_reg;
        last_next       = last_reg;
        align_next      = align_reg;
        tag_next        = tag_reg;
        bytes_left_next = bytes_left_reg;
        skip_next       = skip_reg;
        pad_next        = pad_reg;
        held_next       = held_reg;
        res             = '0;

        if (item.dump)
        begin
            phase_next      = tcwp_pkg::PH_IDLE;
            ioc_next        = 1'b0;
            last_next       = 1'b0;
            align_next      = 2'd0;
            tag_next        = '0;
            bytes_left_next = '0;
            skip_next       = '0;
            pad_next        = '0;
            held_next       = '0;
        end
        else if (held_reg >= capacity)
        begin
            res.overflow_flag = 1'b1;
        end
        else
        begin
            held_next = held_reg + 12'd1;
            case (phase_reg)
                tcwp_pkg::PH_IDLE:
                begin
                    ioc_next        = item.word[31];
                    align_next      = item.word[25:24];
                    last_next       = item.word[12];
                    bytes_left_next = item.word[10:0];
                    skip_next       = item.word[20:16];
                    pad_next        = '0;
                    phase_next      = tcwp_pkg::PH_CMDB;
                end
                tcwp_pkg::PH_CMDB:
                begin
                    tag_next = item.word[31:16];
                    case (align_reg)
                        tcwp_pkg::ALIGN_4: pad_next = {1'b0, 2'd0 - span[3:2]};
                        tcwp_pkg::ALIGN_8: pad_next = 3'd0 - span[4:2];
                        default:           pad_next = '0;
                    endcase
                    phase_next = tcwp_pkg::PH_DATA;
                end
                tcwp_pkg::PH_DATA:
                begin
                    if (skip_reg[4:2] != 3'd0)
                    begin
                        skip_next = skip_reg - 5'd4;
                    end
                    else
                    begin
                        if (bytes_left_reg == '0 && pad_reg != '0)
                        begin
                            pad_next = pad_reg - 3'd1;
                        end
                        else
                        begin
                            res.out_bytes   = shifted & tcwp_pkg::byte_mask(emit_n);
                            res.out_count   = emit_n;
                            skip_next       = '0;
                            bytes_left_next = bytes_left_reg - {8'b0, emit_n};
                        end
                        if (bytes_left_next == '0 && pad_next == '0)
                        begin
                            if (last_reg)
                            begin
                                res.packet_end = 1'b1;
                                if (item.status_room)
                                begin
                                    res.status_push      = 1'b1;
                                    res.status_word      = tag_reg;
                                    res.status_full_flag = item.status_fill;
                                end
                                held_next = '0;
                            end
                            res.ioc_flag = ioc_reg;
                            phase_next   = tcwp_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = tcwp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            result_next    = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tcwp_pkg::PH_IDLE;
            ioc_reg        <= 1'b0;
            last_reg       <= 1'b0;
            align_reg      <= 2'd0;
            tag_reg        <= '0;
            bytes_left_reg <= '0;
            skip_reg       <= '0;
            pad_reg        <= '0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                ioc_reg        <= ioc_next;
                last_reg       <= last_next;
                align_reg      <= align_next;
                tag_reg        <= tag_next;
                bytes_left_reg <= bytes_left_next;
                skip_reg       <= skip_next;
                pad_reg        <= pad_next;
                held_reg       <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    `TCWP_ASSERT_NEXT(a_dump_restarts, clk, rst_n, take && item.dump,
        phase_reg == tcwp_pkg::PH_IDLE && held_reg == '0,
        "dump did not restart the parser")
    `TCWP_ASSERT_NOW(a_push_needs_end, clk, rst_n, out_valid_reg && result_reg.status_push,
        result_reg.packet_end,
        "status pushed without a packet end")
    `TCWP_ASSERT_NOW(a_overflow_silent, clk, rst_n, out_valid_reg && result_reg.overflow_flag,
        result_reg.out_count == '0 && !result_reg.packet_end,
        "dropped word produced payload")
    `TCWP_ASSERT_NEXT(a_overflow_holds, clk, rst_n, take && !item.dump && held_reg >= capacity,
        $stable(held_reg) && $stable(phase_reg),
        "dropped word changed parser state")

endmodule

[rtl/tx_command_word_parser_core.sv]
// Top level of the transmit command word parser with its configuration port.
`timescale 1ns / 1ps
// Parses the words written to a transmit data FIFO: command A, command B,
// then payload and pad words, giving one result transfer for every input
// transfer (payload bytes, packet end, status push and flags). A new word
// can be taken on every clock cycle while the result output is not stalled;
// a word's result is presented through the input register, the two-entry
// queue and the result register. The parser state is updated by one step
// in the back stage, which sets the rate at one word per cycle when
// out_ready does not hold results back. The FIFO capacity register sits at
// byte address 0 of the APB port and may be written only while the parser
// is idle.
module tx_command_word_parser_core #(
    parameter int STATUS_FIFO_DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [tcwp_pkg::WORD_W-1:0]   word,
    input  logic [tcwp_pkg::SCOUNT_W-1:0] status_fifo_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcwp_pkg::WORD_W-1:0]   out_bytes,
    output logic [tcwp_pkg::COUNT_W-1:0]  out_count,
    output logic                          packet_end,
    output logic                          status_push,
    output logic [tcwp_pkg::TAG_W-1:0]    status_word,
    output logic                          status_full_flag,
    output logic                          ioc_flag,
    output logic                          overflow_flag,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [tcwp_pkg::HELD_W-1:0] capacity_reg;
    logic [tcwp_pkg::HELD_W-1:0] capacity_next;
    logic                        front_valid;
    logic                        front_ready;
    tcwp_pkg::item_t             front_item;
    logic                        queue_valid;
    logic                        queue_ready;
    tcwp_pkg::item_t             queue_item;
    tcwp_pkg::result_t           result;
    logic                        cfg_write;

    assign pready    = 1'b1;
    // Only word-aligned writes reach the register.
    assign cfg_write = psel && penable && pwrite && (paddr[2] == tcwp_pkg::REG_CAPACITY)
                    && (paddr[1:0] == 2'd0);
    assign prdata    = (paddr[2] == tcwp_pkg::REG_CAPACITY)
                     ? {20'd0, capacity_reg} : 32'd0;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg_write)
        begin
            capacity_next = pwdata[tcwp_pkg::HELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= tcwp_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    tcwp_front #(
        .STATUS_FIFO_DEPTH (STATUS_FIFO_DEPTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .cmd               (cmd),
        .word              (word),
        .status_fifo_count (status_fifo_count),
        .push_valid        (front_valid),
        .push_ready        (front_ready),
        .push_item         (front_item)
    );

    tcwp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    tcwp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (capacity_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign out_bytes        = result.out_bytes;
    assign out_count        = result.out_count;
    assign packet_end       = result.packet_end;
    assign status_push      = result.status_push;
    assign status_word      = result.status_word;
    assign status_full_flag = result.status_full_flag;
    assign ioc_flag         = result.ioc_flag;
    assign overflow_flag    = result.overflow_flag;

endmodule

[verif/tx_command_word_parser_core_test.sv]
// Self-checking testbench of the transmit command word parser with random traffic and idling.
`timescale 1ns / 1ps
module tx_command_word_parser_core_test;

    localparam int          STATUS_DEPTH   = 128;
    localparam int          LONG_HOLD      = 64;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam logic [31:0] CMDA_MASK      = 32'h831f_37ff;
    localparam int          IOC_BIT        = 31;
    localparam int          FIRST_SEG_BIT  = 13;
    localparam int          LAST_SEG_BIT   = 12;
    // The register index sits in paddr[2], one 32-bit register per word address.
    localparam logic [2:0]  CAPACITY_ADDR  = {tcwp_pkg::REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic                        dump;
        logic [tcwp_pkg::WORD_W-1:0] word;
        logic [7:0]                  fill;
    } host_write_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            cmd = 1'b0;
    logic [tcwp_pkg::WORD_W-1:0]     word = '0;
    logic [tcwp_pkg::SCOUNT_W-1:0]   status_fifo_count = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [tcwp_pkg::WORD_W-1:0]     out_bytes;
    logic [tcwp_pkg::COUNT_W-1:0]    out_count;
    logic                            packet_end;
    logic                            status_push;
    logic [tcwp_pkg::TAG_W-1:0]      status_word;
    logic                            status_full_flag;
    logic                            ioc_flag;
    logic                            overflow_flag;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [2:0]                      paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    tx_command_word_parser_core #(
        .STATUS_FIFO_DEPTH(STATUS_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .word(word),
        .status_fifo_count(status_fifo_count),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_bytes(out_bytes),
        .out_count(out_count),
        .packet_end(packet_end),
        .status_push(status_push),
        .status_word(status_word),
        .status_full_flag(status_full_flag),
        .ioc_flag(ioc_flag),
        .overflow_flag(overflow_flag),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    host_write_t       host_writes[$];
    tcwp_pkg::result_t predicted_results[$];
    host_write_t       cur_write;
    int                gap_left = 0;
    int                stall_left = 0;
    int                results_done = 0;
    int                mismatches = 0;
    int                idle_cycles = 0;
    int                phase_items = 0;
    bit                idle_on = 1'b1;

    // Tracked copy of the parser state.
    tcwp_pkg::phase_t              trk_phase = tcwp_pkg::PH_IDLE;
    logic [tcwp_pkg::WORD_W-1:0]   trk_cmd_a = '0;
    logic [tcwp_pkg::TAG_W-1:0]    trk_tag = '0;
    logic [tcwp_pkg::SIZE_W-1:0]   trk_left = '0;
    logic [tcwp_pkg::SKIP_W-1:0]   trk_skip = '0;
    logic [tcwp_pkg::PAD_W-1:0]    trk_pad = '0;
    logic [tcwp_pkg::HELD_W-1:0]   trk_held = '0;
    logic [tcwp_pkg::HELD_W-1:0]   trk_capacity = tcwp_pkg::CAPACITY_RESET;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic parse_word(input host_write_t s, output tcwp_pkg::result_t r);
        int          nwords;
        int          total;
        int          take;
        logic [31:0] keep;
        r = '0;
        if (s.dump)
        begin
            trk_phase = tcwp_pkg::PH_IDLE;
            trk_cmd_a = '0;
            trk_tag   = '0;
            trk_left  = '0;
            trk_skip  = '0;
            trk_pad   = '0;
            trk_held  = '0;
        end
        else if (trk_held >= trk_capacity)
        begin
            r.overflow_flag = 1'b1;
        end
        else
        begin
            trk_held = trk_held + 12'd1;
            case (trk_phase)
                tcwp_pkg::PH_CMDB:
                begin
                    nwords  = (int'(trk_left) + int'(trk_skip) + 3) >> 2;
                    trk_tag = s.word[31:16];
                    if (trk_cmd_a[25:24] == tcwp_pkg::ALIGN_4)
                        trk_pad = tcwp_pkg::PAD_W'((-nwords) & 3);
                    else if (trk_cmd_a[25:24] == tcwp_pkg::ALIGN_8)
                        trk_pad = tcwp_pkg::PAD_W'((-nwords) & 7);
                    else
                        trk_pad = '0;
                    trk_phase = tcwp_pkg::PH_DATA;
                end
                tcwp_pkg::PH_DATA:
                begin
                    if (trk_skip >= 4)
                    begin
                        trk_skip = trk_skip - 5'd4;
                    end
                    else
                    begin
                        if (trk_left == 0 && trk_pad != 0)
                        begin
                            trk_pad = trk_pad - 3'd1;
                        end
                        else
                        begin
                            total = int'(trk_left) + int'(trk_skip);
                            take  = ((total < 4) ? total : 4) - int'(trk_skip);
                            keep  = (take == 4) ? 32'hffff_ffff
                                                : ((32'd1 << (8 * take)) - 32'd1);
                            r.out_bytes = (s.word >> (8 * trk_skip)) & keep;
                            r.out_count = tcwp_pkg::COUNT_W'(take);
                            trk_skip = '0;
                            trk_left = trk_left - tcwp_pkg::SIZE_W'(take);
                        end
                        if (trk_left == 0 && trk_pad == 0)
                        begin
                            if (trk_cmd_a[LAST_SEG_BIT])
                            begin
                                r.packet_end = 1'b1;
                                if (int'(s.fill) < STATUS_DEPTH)
                                begin
                                    r.status_push = 1'b1;
                                    r.status_word = trk_tag;
                                    if (int'(s.fill) + 1 >= STATUS_DEPTH)
                                        r.status_full_flag = 1'b1;
                                end
                                trk_held = '0;
                            end
                            if (trk_cmd_a[IOC_BIT])
                                r.ioc_flag = 1'b1;
                            trk_phase = tcwp_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    trk_cmd_a = s.word & CMDA_MASK;
                    trk_left  = trk_cmd_a[10:0];
                    trk_skip  = trk_cmd_a[20:16];
                    trk_pad   = '0;
                    trk_phase = tcwp_pkg::PH_CMDB;
                end
            endcase
        end
    endtask

    // Offers the pending host writes, with a random gap drawn for each transfer.
    always @(posedge clk or negedge rst_n)
    begin : host_driver
        tcwp_pkg::result_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_word(cur_write, r);
                predicted_results.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (host_writes.size() != 0)
                begin
                    cur_write = host_writes.pop_front();
                    in_valid          <= 1'b1;
                    cmd               <= cur_write.dump;
                    word              <= cur_write.word;
                    status_fifo_count <= cur_write.fill;
                    gap_left          <= idle_on ? int'($urandom_range(0, 7)) : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Takes result transfers, stalling at random and twice for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        tcwp_pkg::result_t want;
        int                nxt;
        int                bad;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                bad  = field_diff("out_bytes", want.out_bytes, out_bytes);
                bad += field_diff("out_count", 32'(want.out_count), 32'(out_count));
                bad += field_diff("packet_end", 32'(want.packet_end), 32'(packet_end));
                bad += field_diff("status_push", 32'(want.status_push), 32'(status_push));
                bad += field_diff("status_word", 32'(want.status_word), 32'(status_word));
                bad += field_diff("status_full_flag", 32'(want.status_full_flag),
                                  32'(status_full_flag));
                bad += field_diff("ioc_flag", 32'(want.ioc_flag), 32'(ioc_flag));
                bad += field_diff("overflow_flag", 32'(want.overflow_flag), 32'(overflow_flag));
                mismatches += bad;
            end
            results_done++;
            if (results_done == 60 || results_done == 300)
                nxt = LONG_HOLD;
            else
                nxt = idle_on ? int'($urandom_range(0, 7)) : 0;
            stall_left <= nxt;
            out_ready  <= (nxt == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic logic [7:0] pick_fill();
        case ($urandom_range(0, 9))
            0:       return 8'd128;
            1:       return 8'd127;
            2:       return 8'd126;
            default: return 8'($urandom_range(0, 128));
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic void queue_write(bit dump, logic [31:0] w, logic [7:0] fill);
        host_writes.push_back('{dump, w, fill});
        phase_items++;
    endfunction

    function automatic logic [31:0] command_a(int size, int offset, int align,
                                              bit first, bit last, bit ioc);
        logic [31:0] w;
        w = $urandom() & ~CMDA_MASK;
        w[10:0]          = size[10:0];
        w[20:16]         = offset[4:0];
        w[25:24]         = align[1:0];
        w[FIRST_SEG_BIT] = first;
        w[LAST_SEG_BIT]  = last;
        w[IOC_BIT]       = ioc;
        return w;
    endfunction

    // Queues a whole buffer: command A, command B, then exactly the data words it takes.
    task automatic add_buffer(int size, int offset, int align, bit last, bit ioc, int end_fill);
        int nwords;
        int sk;
        int lf;
        int pd;
        int cnt;
        int take;
        bit done;
        nwords = (size + offset + 3) >> 2;
        if (align == int'(tcwp_pkg::ALIGN_4))
            pd = (-nwords) & 3;
        else if (align == int'(tcwp_pkg::ALIGN_8))
            pd = (-nwords) & 7;
        else
            pd = 0;
        sk   = offset;
        lf   = size;
        cnt  = 0;
        done = 1'b0;
        while (!done)
        begin
            cnt++;
            if (sk >= 4)
            begin
                sk -= 4;
            end
            else
            begin
                if (lf == 0 && pd != 0)
                begin
                    pd--;
                end
                else
                begin
                    take = (((lf + sk) < 4) ? (lf + sk) : 4) - sk;
                    lf -= take;
                    sk = 0;
                end
                if (lf == 0 && pd == 0)
                    done = 1'b1;
            end
        end
        queue_write(1'b0, command_a(size, offset, align, 1'($urandom_range(0, 1)), last, ioc),
                    pick_fill());
        queue_write(1'b0, $urandom(), pick_fill());
        for (int i = 0; i < cnt; i++)
            queue_write(1'b0, pick_word(),
                        (i == cnt - 1 && end_fill >= 0) ? 8'(end_fill) : pick_fill());
    endtask

    // Mostly complete buffers with random content; the rest is cut-off buffers and noise.
    task automatic random_traffic(int count);
        int r;
        int extra;
        phase_items = 0;
        while (phase_items < count)
        begin
            r = $urandom_range(0, 15);
            if (r < 11)
            begin
                add_buffer(($urandom_range(0, 15) == 0) ? $urandom_range(25, 160)
                                                         : $urandom_range(0, 24),
                           $urandom_range(0, 31), $urandom_range(0, 3),
                           $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), -1);
            end
            else if (r < 13)
            begin
                queue_write(1'b0, command_a($urandom_range(0, 2047), $urandom_range(0, 31),
                                            $urandom_range(0, 3), 1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1))),
                            pick_fill());
                extra = $urandom_range(0, 5);
                for (int i = 0; i < extra; i++)
                    queue_write(1'b0, pick_word(), pick_fill());
                if ($urandom_range(0, 1) != 0)
                    queue_write(1'b1, $urandom(), pick_fill());
            end
            else if (r < 14)
            begin
                queue_write(1'b1, $urandom(), pick_fill());
            end
            else
            begin
                queue_write($urandom_range(0, 3) == 0, pick_word(), pick_fill());
            end
        end
    endtask

    // Holds the sender back until every expected result transfer has arrived.
    task automatic drain();
        while (host_writes.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(logic [tcwp_pkg::HELD_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        trk_capacity = value;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed buffers at the reset capacity.
        queue_write(1'b1, 32'hffff_ffff, 8'd0);
        add_buffer(7, 0, 0, 1'b1, 1'b1, 0);
        add_buffer(0, 0, 0, 1'b1, 1'b0, 128);
        add_buffer(5, 6, int'(tcwp_pkg::ALIGN_4), 1'b1, 1'b1, 127);
        add_buffer(2, 0, 0, 1'b0, 1'b1, 5);
        queue_write(1'b0, command_a(2047, 31, 3, 1'b1, 1'b1, 1'b1), 8'd128);
        queue_write(1'b0, 32'hffff_ffff, 8'd0);
        queue_write(1'b0, 32'hffff_ffff, 8'd0);
        queue_write(1'b1, 32'h0000_0000, 8'd128);
        queue_write(1'b0, 32'h0000_0000, 8'd0);
        queue_write(1'b0, 32'h0000_0000, 8'd0);
        queue_write(1'b0, 32'h0000_0000, 8'd0);
        drain();

        write_capacity(12'd3712);
        random_traffic(90);
        drain();
        write_capacity(12'd1);
        random_traffic(40);
        drain();
        // With no capacity every word that is not a dump is dropped.
        write_capacity(12'd0);
        random_traffic(20);
        drain();
        write_capacity(12'($urandom_range(2, 40)));
        idle_on = 1'b0;
        random_traffic(90);
        drain();
        idle_on = 1'b1;
        write_capacity(12'($urandom_range(41, 3711)));
        random_traffic(110);
        drain();
        write_capacity(tcwp_pkg::CAPACITY_RESET);
        random_traffic(100);
        drain();

        if (mismatches == 0 && predicted_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
